// ===== src/anxb_pkg.sv =====
// Shared types, constants and helpers for the Annex-B NAL unit splitter.
package anxb_pkg;

  // Longest packet the length counters are sized for.
  localparam int MAX_PACKET_BYTES = 65536;

  // Payload length saturates here.
  localparam logic [15:0] LEN_CAP =
    16'((MAX_PACKET_BYTES < 65535) ? MAX_PACKET_BYTES : 65535);

  // Most results that one input byte can cause.
  localparam int MAX_RESULTS = 4;

  // Start-code lengths as reported on the result channel.
  localparam logic [2:0] SC_SHORT = 3'd3;
  localparam logic [2:0] SC_LONG  = 3'd4;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_EXPECT,
    PH_UNIT,
    PH_DROP
  } phase_t;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  zero_run;
    logic [7:0]  held_byte;
    logic        held_valid;
    logic        long_code;
    logic        first_pending;
    logic [15:0] payload_count;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:         PH_EXPECT,
    zero_run:      2'd0,
    held_byte:     8'h00,
    held_valid:    1'b0,
    long_code:     1'b0,
    first_pending: 1'b0,
    payload_count: 16'd0
  };

  // One result item.
  typedef struct packed {
    logic [7:0]  nal_byte;
    logic        byte_valid;
    logic        nal_first;
    logic        nal_last;
    logic [2:0]  start_code_len;
    logic [15:0] nal_length;
    logic        bad_start;
    logic        run_last;
  } res_t;

  // Start-code length for the current unit.
  function automatic logic [2:0] code_len(logic long_code);
    return long_code ? SC_LONG : SC_SHORT;
  endfunction

  // Result that carries one payload byte; the count is already updated.
  function automatic res_t payload_res(logic [7:0] b, logic first, logic last,
                                       logic long_code, logic [15:0] count);
    res_t r;
    r                = '0;
    r.nal_byte       = b;
    r.byte_valid     = 1'b1;
    r.nal_first      = first;
    r.nal_last       = last;
    r.start_code_len = code_len(long_code);
    r.nal_length     = last ? count : 16'd0;
    return r;
  endfunction

  // Result for a unit with no payload.
  function automatic res_t empty_res(logic long_code);
    res_t r;
    r                = '0;
    r.nal_first      = 1'b1;
    r.nal_last       = 1'b1;
    r.start_code_len = code_len(long_code);
    return r;
  endfunction

  // Flag result for a packet that does not open with a start code.
  function automatic res_t bad_res();
    res_t r;
    r           = '0;
    r.bad_start = 1'b1;
    return r;
  endfunction

endpackage

// ===== src/anxb_parse.sv =====
// Per-byte start-code parser: next state and the results one byte causes.
module anxb_parse (
  input  logic [7:0]                                  data_byte,
  input  logic                                        packet_last,
  input  anxb_pkg::state_t                            st,
  output anxb_pkg::state_t                            st_next,
  output anxb_pkg::res_t [anxb_pkg::MAX_RESULTS-1:0] res,
  output logic [2:0]                                  res_count
);

  always_comb begin
    anxb_pkg::state_t s;
    logic [2:0] n;
    logic [2:0] np;
    logic       use_b;
    logic       do_flush;
    logic [7:0] pb;

    s        = st;
    n        = 3'd0;
    np       = 3'd0;
    use_b    = 1'b0;
    do_flush = 1'b0;
    pb       = 8'h00;
    res      = '0;

    case (s.phase)
      anxb_pkg::PH_UNIT: begin
        if (data_byte == 8'h01 && s.zero_run >= 2'd2) begin
          // A new start code closes the current unit.
          if (s.held_valid) begin
            if (s.payload_count < anxb_pkg::LEN_CAP) begin
              s.payload_count = s.payload_count + 16'd1;
            end
            res[n[1:0]] = anxb_pkg::payload_res(s.held_byte, s.first_pending, 1'b1,
                                                s.long_code, s.payload_count);
          end else begin
            res[n[1:0]] = anxb_pkg::empty_res(s.long_code);
          end
          n               = n + 3'd1;
          s.long_code     = (s.zero_run == 2'd3);
          s.zero_run      = 2'd0;
          s.held_valid    = 1'b0;
          s.first_pending = 1'b1;
          s.payload_count = 16'd0;
          do_flush        = packet_last;
        end else if (data_byte == 8'h00) begin
          // Zeros may still start a code; a fourth one is payload.
          if (s.zero_run < 2'd3) begin
            s.zero_run = s.zero_run + 2'd1;
          end else begin
            np = 3'd1;
          end
          if (packet_last) begin
            np       = np + {1'b0, s.zero_run};
            do_flush = 1'b1;
          end
        end else begin
          // Any other byte: pending zeros and the byte are payload.
          np         = {1'b0, s.zero_run} + 3'd1;
          use_b      = 1'b1;
          s.zero_run = 2'd0;
          do_flush   = packet_last;
        end
      end

      anxb_pkg::PH_DROP: begin
        if (packet_last) begin
          s.phase    = anxb_pkg::PH_EXPECT;
          s.zero_run = 2'd0;
        end
      end

      default: begin
        // A closing byte held back by the previous packet goes out first.
        if (s.held_valid) begin
          if (s.payload_count < anxb_pkg::LEN_CAP) begin
            s.payload_count = s.payload_count + 16'd1;
          end
          res[n[1:0]] = anxb_pkg::payload_res(s.held_byte, s.first_pending, 1'b1,
                                              s.long_code, s.payload_count);
          n               = n + 3'd1;
          s.first_pending = 1'b0;
          s.held_valid    = 1'b0;
        end
        if (data_byte == 8'h00 && s.zero_run < 2'd3) begin
          s.zero_run = s.zero_run + 2'd1;
          if (packet_last) begin
            res[n[1:0]] = anxb_pkg::bad_res();
            n           = n + 3'd1;
            s.zero_run  = 2'd0;
            s.phase     = anxb_pkg::PH_EXPECT;
          end
        end else if (data_byte == 8'h01 && s.zero_run >= 2'd2) begin
          s.long_code     = (s.zero_run == 2'd3);
          s.zero_run      = 2'd0;
          s.phase         = anxb_pkg::PH_UNIT;
          s.first_pending = 1'b1;
          s.payload_count = 16'd0;
          s.held_valid    = 1'b0;
          do_flush        = packet_last;
        end else begin
          res[n[1:0]] = anxb_pkg::bad_res();
          n           = n + 3'd1;
          s.zero_run  = 2'd0;
          s.phase     = packet_last ? anxb_pkg::PH_EXPECT : anxb_pkg::PH_DROP;
        end
      end
    endcase

    // Push payload bytes; each push releases the byte held before it.
    for (int i = 0; i < anxb_pkg::MAX_RESULTS; i++) begin
      if (3'(i) < np) begin
        pb = (use_b && (3'(i) == np - 3'd1)) ? data_byte : 8'h00;
        if (s.held_valid) begin
          if (s.payload_count < anxb_pkg::LEN_CAP) begin
            s.payload_count = s.payload_count + 16'd1;
          end
          if (n < 3'd4) begin
            res[n[1:0]] = anxb_pkg::payload_res(s.held_byte, s.first_pending, 1'b0,
                                                s.long_code, s.payload_count);
            n           = n + 3'd1;
          end
          s.first_pending = 1'b0;
        end
        s.held_byte  = pb;
        s.held_valid = 1'b1;
      end
    end

    // Packet end closes the last unit; with no slot left the close stays held.
    if (do_flush) begin
      if (s.held_valid) begin
        if (n < 3'd4) begin
          if (s.payload_count < anxb_pkg::LEN_CAP) begin
            s.payload_count = s.payload_count + 16'd1;
          end
          res[n[1:0]]  = anxb_pkg::payload_res(s.held_byte, s.first_pending, 1'b1,
                                               s.long_code, s.payload_count);
          n            = n + 3'd1;
          s.held_valid = 1'b0;
        end
      end else if (n < 3'd4) begin
        res[n[1:0]] = anxb_pkg::empty_res(s.long_code);
        n           = n + 3'd1;
      end
      s.zero_run      = 2'd0;
      s.phase         = anxb_pkg::PH_EXPECT;
      s.first_pending = 1'b0;
    end

    // Mark the final result of this byte.
    if (n != 3'd0) begin
      res[2'(n - 3'd1)].run_last = 1'b1;
    end

    st_next   = s;
    res_count = n;
  end

endmodule

// ===== src/annexb_nal_splitter.sv =====
// Annex-B NAL splitter: the first result of a byte appears in the cycle after the byte is transferred.
// A byte that causes at most one result is taken every cycle while nal_stall is low;
// a byte that causes more (up to four) stalls the input while the result buffer drains.
// The next byte is taken in the cycle the last buffered result is transferred.
// Reset (rst, synchronous) empties the result buffer and returns the parser to
// waiting for a packet start code.
module annexb_nal_splitter (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        packet_last,
  output logic        nal_valid,
  input  logic        nal_stall,
  output logic [7:0]  nal_byte,
  output logic        byte_valid,
  output logic        nal_first,
  output logic        nal_last,
  output logic [2:0]  start_code_len,
  output logic [15:0] nal_length,
  output logic        bad_start,
  output logic        run_last
);

  anxb_pkg::state_t                            st;
  anxb_pkg::state_t                            st_next;
  anxb_pkg::res_t [anxb_pkg::MAX_RESULTS-1:0] res;
  anxb_pkg::res_t [anxb_pkg::MAX_RESULTS-1:0] rbuf;
  anxb_pkg::res_t                              cur;
  logic [2:0]                                  res_count;
  logic [2:0]                                  pend;
  logic [1:0]                                  head;
  logic                                        in_xfer;
  logic                                        out_xfer;

  anxb_parse u_parse (
    .data_byte   (data_byte),
    .packet_last (packet_last),
    .st          (st),
    .st_next     (st_next),
    .res         (res),
    .res_count   (res_count)
  );

  // Take a byte once the buffer is empty or its last result leaves now.
  assign data_stall = (pend > 3'd1) || ((pend == 3'd1) && nal_stall);
  assign in_xfer    = data_valid && !data_stall;
  assign nal_valid  = (pend != 3'd0);
  assign out_xfer   = nal_valid && !nal_stall;

  // Parser state and buffer occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= anxb_pkg::STATE_RESET;
      pend <= 3'd0;
      head <= 2'd0;
    end else if (in_xfer) begin
      st   <= st_next;
      pend <= res_count;
      head <= 2'd0;
    end else if (out_xfer) begin
      pend <= pend - 3'd1;
      head <= head + 2'd1;
    end
  end

  // Result buffer loaded with everything one byte causes.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rbuf <= res;
    end
  end

  // Present the head result.
  assign cur            = rbuf[head];
  assign nal_byte       = cur.nal_byte;
  assign byte_valid     = cur.byte_valid;
  assign nal_first      = cur.nal_first;
  assign nal_last       = cur.nal_last;
  assign start_code_len = cur.start_code_len;
  assign nal_length     = cur.nal_length;
  assign bad_start      = cur.bad_start;
  assign run_last       = cur.run_last;

endmodule

// ===== src/anxb_checker.sv =====
// Port-level checks for the Annex-B NAL splitter, bound to the top level.
module anxb_checker (
  input logic        clk,
  input logic        rst,
  input logic        data_stall,
  input logic        nal_valid,
  input logic        nal_stall,
  input logic [7:0]  nal_byte,
  input logic        byte_valid,
  input logic        nal_first,
  input logic        nal_last,
  input logic [2:0]  start_code_len,
  input logic [15:0] nal_length,
  input logic        bad_start,
  input logic        run_last
);

  // A stalled result stays offered and unchanged.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    nal_valid && nal_stall |=> nal_valid &&
      $stable({nal_byte, byte_valid, nal_first, nal_last, start_code_len,
               nal_length, bad_start, run_last}))
    else $error("result withdrawn or changed while stalled");

  // A flag result carries nothing of a unit.
  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    nal_valid && bad_start |-> !byte_valid && !nal_first && !nal_last &&
                               (start_code_len == 3'd0) && (nal_length == 16'd0))
    else $error("bad-start result carries unit fields");

  // Length shows only on the closing result of a unit.
  a_len_on_last: assert property (@(posedge clk) disable iff (rst)
    nal_valid && !nal_last |-> (nal_length == 16'd0))
    else $error("length on a result that is not the last of its unit");

  // Unit results report a legal start-code length.
  a_code_len: assert property (@(posedge clk) disable iff (rst)
    nal_valid && !bad_start |-> (start_code_len == 3'd3) || (start_code_len == 3'd4))
    else $error("illegal start-code length");

  // The input is only held off while results are waiting.
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    !nal_valid |-> !data_stall)
    else $error("input stalled with no result waiting");

endmodule

bind annexb_nal_splitter anxb_checker u_anxb_checker (.*);

// ===== tb/tb_annexb_nal_splitter.sv =====
// Self-checking testbench for the Annex-B NAL unit splitter.
`timescale 1ns / 1ps

module tb_annexb_nal_splitter;

  localparam int RANDOM_BYTES = 330;
  localparam int HOLD_CYCLES  = 150;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef logic [7:0] pkt_t[$];

  // Receiver stall patterns.
  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        packet_last = 1'b0;
  logic        nal_valid;
  logic        nal_stall = 1'b0;
  logic [7:0]  nal_byte;
  logic        byte_valid;
  logic        nal_first;
  logic        nal_last;
  logic [2:0]  start_code_len;
  logic [15:0] nal_length;
  logic        bad_start;
  logic        run_last;

  // Splitter state as predicted from the transferred bytes.
  anxb_pkg::phase_t sp_phase = anxb_pkg::PH_EXPECT;
  logic [1:0]  sp_zeros = 2'd0;
  logic [7:0]  sp_held_byte = 8'h00;
  logic        sp_held_ok = 1'b0;
  logic        sp_long = 1'b0;
  logic        sp_first_due = 1'b0;
  logic [15:0] sp_count = 16'd0;

  // Results of the byte being predicted, and all results still awaited.
  anxb_pkg::res_t step_out[$];
  anxb_pkg::res_t pending_nal[$];

  int errors = 0;
  int cycle_count = 0;
  int hold_reqs = 0;
  bit tx_idle_en = 1'b1;
  int tx_burst_left = 0;

  annexb_nal_splitter DUT (
    .clk            (clk),
    .rst            (rst),
    .data_valid     (data_valid),
    .data_stall     (data_stall),
    .data_byte      (data_byte),
    .packet_last    (packet_last),
    .nal_valid      (nal_valid),
    .nal_stall      (nal_stall),
    .nal_byte       (nal_byte),
    .byte_valid     (byte_valid),
    .nal_first      (nal_first),
    .nal_last       (nal_last),
    .start_code_len (start_code_len),
    .nal_length     (nal_length),
    .bad_start      (bad_start),
    .run_last       (run_last)
  );

  always #5 clk = ~clk;

  // Appends one result for the current byte; a byte yields at most four.
  function automatic void queue_result(logic [7:0] b, logic v, logic f, logic l,
                                       logic [2:0] sc, logic [15:0] len, logic bad);
    anxb_pkg::res_t r;
    if (step_out.size() >= anxb_pkg::MAX_RESULTS) return;
    r.nal_byte       = b;
    r.byte_valid     = v;
    r.nal_first      = f;
    r.nal_last       = l;
    r.start_code_len = sc;
    r.nal_length     = len;
    r.bad_start      = bad;
    r.run_last       = 1'b0;
    step_out.push_back(r);
  endfunction

  // Emits a payload byte and bumps the saturating unit length.
  function automatic void emit_data(logic [7:0] b, logic last);
    logic f;
    f = sp_first_due;
    if (sp_count < anxb_pkg::LEN_CAP) sp_count++;
    sp_first_due = 1'b0;
    queue_result(b, 1'b1, f, last, sp_long ? anxb_pkg::SC_LONG : anxb_pkg::SC_SHORT,
                 last ? sp_count : 16'd0, 1'b0);
  endfunction

  function automatic void emit_empty_unit();
    sp_first_due = 1'b0;
    queue_result(8'h00, 1'b0, 1'b1, 1'b1,
                 sp_long ? anxb_pkg::SC_LONG : anxb_pkg::SC_SHORT, 16'd0, 1'b0);
  endfunction

  // The newest payload byte is held back so that it can carry the unit end.
  function automatic void shift_in(logic [7:0] v);
    if (sp_held_ok) emit_data(sp_held_byte, 1'b0);
    sp_held_byte = v;
    sp_held_ok   = 1'b1;
  endfunction

  // Packet end: pending zeros join the unit, then the unit is closed.
  function automatic void close_unit();
    for (int k = 0; k < sp_zeros; k++) shift_in(8'h00);
    sp_zeros = 2'd0;
    if (sp_held_ok) begin
      // With no room left the closing result waits for the next byte.
      if (step_out.size() < anxb_pkg::MAX_RESULTS) begin
        emit_data(sp_held_byte, 1'b1);
        sp_held_ok = 1'b0;
      end
    end else begin
      emit_empty_unit();
    end
    sp_phase     = anxb_pkg::PH_EXPECT;
    sp_first_due = 1'b0;
  endfunction

  function automatic void flag_bad_packet(logic last);
    queue_result(8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 16'd0, 1'b1);
    sp_zeros = 2'd0;
    sp_phase = last ? anxb_pkg::PH_EXPECT : anxb_pkg::PH_DROP;
  endfunction

  // Predicts the results of one transferred byte and queues them.
  function automatic void split_byte(logic [7:0] b, logic last);
    anxb_pkg::res_t r;
    step_out = {};
    case (sp_phase)
      anxb_pkg::PH_UNIT: begin
        if (b == 8'h01 && sp_zeros >= 2) begin
          // A start code closes the current unit and opens the next one.
          if (sp_held_ok) emit_data(sp_held_byte, 1'b1);
          else emit_empty_unit();
          sp_long      = (sp_zeros == 2'd3);
          sp_zeros     = 2'd0;
          sp_held_ok   = 1'b0;
          sp_first_due = 1'b1;
          sp_count     = 16'd0;
          if (last) close_unit();
        end else if (b == 8'h00) begin
          // Zeros beyond three cannot be part of the next start code.
          if (sp_zeros < 2'd3) sp_zeros++;
          else shift_in(8'h00);
          if (last) close_unit();
        end else begin
          for (int k = 0; k < sp_zeros; k++) shift_in(8'h00);
          sp_zeros = 2'd0;
          shift_in(b);
          if (last) close_unit();
        end
      end
      anxb_pkg::PH_DROP: begin
        if (last) begin
          sp_phase = anxb_pkg::PH_EXPECT;
          sp_zeros = 2'd0;
        end
      end
      default: begin
        // A closing result left over from the previous packet goes first.
        if (sp_held_ok) begin
          emit_data(sp_held_byte, 1'b1);
          sp_held_ok = 1'b0;
        end
        if (b == 8'h00 && sp_zeros < 2'd3) begin
          sp_zeros++;
          if (last) flag_bad_packet(1'b1);
        end else if (b == 8'h01 && sp_zeros >= 2) begin
          sp_long      = (sp_zeros == 2'd3);
          sp_zeros     = 2'd0;
          sp_phase     = anxb_pkg::PH_UNIT;
          sp_first_due = 1'b1;
          sp_count     = 16'd0;
          sp_held_ok   = 1'b0;
          if (last) close_unit();
        end else begin
          flag_bad_packet(last);
        end
      end
    endcase
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.run_last = 1'b1;
      step_out.push_back(r);
    end
    foreach (step_out[i]) pending_nal.push_back(step_out[i]);
  endfunction

  function automatic string show_nal(anxb_pkg::res_t r);
    return $sformatf("byte=%02h bv=%0d first=%0d last=%0d sc=%0d len=%0d bad=%0d rl=%0d",
                     r.nal_byte, r.byte_valid, r.nal_first, r.nal_last,
                     r.start_code_len, r.nal_length, r.bad_start, r.run_last);
  endfunction

  // Predict on every input transfer and check every output transfer.
  always @(posedge clk) begin
    anxb_pkg::res_t got;
    anxb_pkg::res_t want;
    if (!rst) begin
      if (data_valid && !data_stall) split_byte(data_byte, packet_last);
      if (nal_valid && !nal_stall) begin
        got.nal_byte       = nal_byte;
        got.byte_valid     = byte_valid;
        got.nal_first      = nal_first;
        got.nal_last       = nal_last;
        got.start_code_len = start_code_len;
        got.nal_length     = nal_length;
        got.bad_start      = bad_start;
        got.run_last       = run_last;
        if (pending_nal.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %s", $time, show_nal(got));
          errors++;
        end else begin
          want = pending_nal.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected %s, actual %s", $time,
                     show_nal(want), show_nal(got));
            errors++;
          end
        end
      end
    end
  end

  // Receiver: switches between stall patterns on its own, and honors long hold requests.
  rx_mode_t rx_mode = RX_FREE;
  int rx_left = 0;
  int rx_tick = 0;
  int hold_left = 0;
  int hold_seen = 0;

  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      nal_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:  nal_stall <= 1'b0;
        RX_LIGHT: nal_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: nal_stall <= ($urandom_range(0, 9) < 7);
        default:  nal_stall <= ((rx_tick % 5) < 2);
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one byte and waits for its transfer; idles in bursts when enabled.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (tx_idle_en && tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      data_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    data_valid  = 1'b1;
    data_byte   = b;
    packet_last = last;
    do @(posedge clk); while (data_stall);
    @(negedge clk);
    data_valid = 1'b0;
  endtask

  task automatic send_packet(input pkt_t p);
    foreach (p[i]) send_byte(p[i], i == p.size() - 1);
  endtask

  // Short and long start codes, an extra zero kept by the unit, an empty unit,
  // and trailing zeros at the packet end.
  task automatic test_unit_splitting();
    pkt_t p;
    p = '{8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
          8'h00, 8'h00, 8'h01, 8'h00};
    send_packet(p);
  endtask

  // A leading non-zero byte, four leading zeros, and a packet ending mid start code.
  task automatic test_bad_starts();
    pkt_t p;
    p = '{8'h5A};
    send_packet(p);
    p = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_packet(p);
    p = '{8'h00, 8'h00};
    send_packet(p);
  endtask

  // A final byte that needs more than four results; the closing result comes
  // out ahead of the next packet's empty unit.
  task automatic test_held_close();
    pkt_t p;
    p = '{8'h00, 8'h00, 8'h01, 8'hAA, 8'h00, 8'h00, 8'h00, 8'hBB};
    send_packet(p);
    p = '{8'h00, 8'h00, 8'h00, 8'h01};
    send_packet(p);
  endtask

  // The receiver holds off for a long stretch while bytes keep coming.
  task automatic test_input_backpressure();
    pkt_t p;
    p = '{8'h00, 8'h00, 8'h00, 8'h01};
    repeat (44) p.push_back(8'($urandom_range(2, 255)));
    tx_idle_en = 1'b0;
    hold_reqs++;
    send_packet(p);
    tx_idle_en = 1'b1;
  endtask

  // Mostly well-formed packets with zero-heavy payloads, plus noise and broken packets.
  task automatic test_random_packets();
    pkt_t p;
    int sent;
    int kind;
    int len;
    int r;
    int cut;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      p = {};
      kind = $urandom_range(0, 19);
      tx_idle_en = ($urandom_range(0, 4) != 0);
      if (kind < 2) begin
        len = $urandom_range(1, 8);
        repeat (len) p.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 1) p.push_back(8'h00);
          p.push_back(8'h00);
          p.push_back(8'h00);
          p.push_back(8'h01);
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
          repeat (len) begin
            r = $urandom_range(0, 9);
            p.push_back(r < 3 ? 8'h00 : (r == 3 ? 8'h01 : 8'($urandom)));
          end
        end
        // Truncated packet, or a junk byte ahead of the first start code.
        if (kind == 2) begin
          cut = $urandom_range(1, p.size());
          while (p.size() > cut) void'(p.pop_back());
        end else if (kind == 3) begin
          p.push_front(8'($urandom_range(1, 255)));
        end
      end
      send_packet(p);
      sent += p.size();
    end
    tx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_unit_splitting();
    test_bad_starts();
    test_held_close();
    test_input_backpressure();
    test_random_packets();

    while (pending_nal.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
